/* rtl/cdq_pkg.sv */
// Shared types and constants for the circular deque block.
// No dependencies; every other file but cdq_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int DEPTH     = 1024;
  localparam int ELEM_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);       // DEPTH is a power of two
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MOVE,
    S_FINAL,
    S_DONE
  } state_t;

  // one memory access bundle: read port and write port
  typedef struct packed {
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [ELEM_BITS-1:0] wdata;
  } ram_req_t;

  // block move request for the mover
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              up;
    logic [CNT_W-1:0]  moves;
  } move_cmd_t;

endpackage

`default_nettype wire

/* rtl/cdq_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on cdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_req_if import cdq_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [CNT_W-1:0]  position;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, position, write_data, input ready);
  modport sink   (input valid, command, position, write_data, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  status_t           status;
  logic [CNT_W-1:0]  count;

  modport source (output valid, read_data, status, count, input ready);
  modport sink   (input valid, read_data, status, count, output ready);
endinterface

`default_nettype wire

/* rtl/circular_deque_middle_insert_erase.sv */
// Circular deque with insert/erase at any position; elements in one RAM.
// Errors and clear go straight to the reply, a read adds a RAM read; insert
// and erase move m elements (m = the shorter side, at most DEPTH/2), one
// element per cycle through the single RAM write port, and insert then writes
// the new element. Reset (sync, rst high): empty, head 0; RAM not cleared.
// Depends on cdq_pkg, cdq_if, cdq_ram, cdq_mover.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_middle_insert_erase import cdq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  cdq_req_if.sink   request,
  cdq_rsp_if.source response
);

  // ---------------------------------------------------------------------
  // Architectural state: head slot and element count
  // ---------------------------------------------------------------------
  state_t            state, state_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count_q, count_next;

  // per-item working registers (payload, no reset)
  logic [ADDR_W-1:0]    fin_addr;
  logic [ELEM_BITS-1:0] fin_data;
  logic                 is_insert;
  status_t              res_status, status_next;
  logic [CNT_W-1:0]     res_count;
  logic [ELEM_BITS-1:0] res_data;

  // response register
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  status_t           out_status;
  logic [CNT_W-1:0]  out_count;

  logic accept;
  logic load_out;
  logic mv_busy;

  ram_req_t             mv_req, top_req, ram_req;
  move_cmd_t            mv_cmd;
  logic [ELEM_BITS-1:0] ram_rdata;

  // ---------------------------------------------------------------------
  // Request decode, all from the registered head/count
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]  pos;
  logic [ADDR_W-1:0] pos_a, cnt_a;
  logic [CNT_W-1:0]  back_len;     // count - pos
  logic [CNT_W-1:0]  erase_back;   // count - 1 - pos
  logic              pos_lt, pos_gt, full;
  logic              do_read, do_move;
  logic [ADDR_W-1:0] fin_addr_next;

  assign pos        = request.position;
  assign pos_a      = pos[ADDR_W-1:0];
  assign cnt_a      = count_q[ADDR_W-1:0];
  assign back_len   = count_q - pos;
  assign erase_back = count_q - pos - CNT_W'(1);
  assign pos_lt     = pos < count_q;
  assign pos_gt     = pos > count_q;
  assign full       = count_q == CNT_W'(DEPTH);

  always_comb begin
    head_next     = head;
    count_next    = count_q;
    status_next   = ST_OK;
    do_read       = 1'b0;
    do_move       = 1'b0;
    fin_addr_next = head + pos_a;
    mv_cmd        = '0;
    unique case (request.command)
      CMD_READ: begin
        if (pos_lt) do_read = 1'b1;
        else        status_next = ST_RANGE;
      end
      CMD_INSERT: begin
        if (pos_gt) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_move    = 1'b1;
          count_next = count_q + CNT_W'(1);
          if (pos < back_len) begin
            // front side: head steps back, elements 0..pos-1 slide down
            head_next     = head - ADDR_W'(1);
            mv_cmd.src    = head;
            mv_cmd.dst    = head - ADDR_W'(1);
            mv_cmd.up     = 1'b1;
            mv_cmd.moves  = pos;
            fin_addr_next = head - ADDR_W'(1) + pos_a;
          end else begin
            // back side (also on a tie): tail grows
            mv_cmd.dst    = head + cnt_a;
            mv_cmd.src    = head + cnt_a - ADDR_W'(1);
            mv_cmd.up     = 1'b0;
            mv_cmd.moves  = back_len;
          end
        end
      end
      CMD_ERASE: begin
        if (!pos_lt) begin
          status_next = ST_RANGE;
        end else begin
          do_move    = 1'b1;
          count_next = count_q - CNT_W'(1);
          mv_cmd.dst = head + pos_a;
          if (pos < erase_back) begin
            mv_cmd.src   = head + pos_a - ADDR_W'(1);
            mv_cmd.up    = 1'b0;
            mv_cmd.moves = pos;
            head_next    = head + ADDR_W'(1);
          end else begin
            mv_cmd.src   = head + pos_a + ADDR_W'(1);
            mv_cmd.up    = 1'b1;
            mv_cmd.moves = erase_back;
          end
          // emptied sequence restarts at slot 0
          if (count_q == CNT_W'(1)) head_next = '0;
        end
      end
      CMD_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: ;
    endcase
    mv_cmd.start = accept & do_move;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign accept         = request.valid & request.ready;
  assign request.ready  = (state == S_IDLE);
  assign load_out       = (state == S_DONE) & (!out_valid | response.ready);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (do_read)      state_next = S_READ;
          else if (do_move) state_next = S_MOVE;
          else              state_next = S_DONE;
        end
      end
      S_READ:  state_next = S_DONE;
      S_MOVE: begin
        if (!mv_busy) state_next = is_insert ? S_FINAL : S_DONE;
      end
      S_FINAL: state_next = S_DONE;
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // head/count commit at acceptance; the mover already holds its addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count_q <= '0;
    end else if (accept) begin
      head    <= head_next;
      count_q <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fin_addr   <= fin_addr_next;
      fin_data   <= request.write_data[ELEM_BITS-1:0];
      is_insert  <= (request.command == CMD_INSERT);
      res_status <= status_next;
      res_count  <= count_next;
      res_data   <= '0;
    end else if (state == S_READ) begin
      res_data <= ram_rdata;
    end
  end

  // ---------------------------------------------------------------------
  // Response register: holds one finished result while the next item runs
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data   <= DATA_W'(res_data);
      out_status <= res_status;
      out_count  <= res_count;
    end
  end

  assign response.valid     = out_valid;
  assign response.read_data = out_data;
  assign response.status    = out_status;
  assign response.count     = out_count;

  // ---------------------------------------------------------------------
  // Element store and mover; the mover owns the RAM while busy
  // ---------------------------------------------------------------------
  assign top_req.re    = accept & do_read;
  assign top_req.raddr = head + pos_a;
  assign top_req.we    = (state == S_FINAL);
  assign top_req.waddr = fin_addr;
  assign top_req.wdata = fin_data;

  assign ram_req = mv_busy ? mv_req : top_req;

  cdq_mover u_mover (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mv_cmd),
    .rd_data (ram_rdata),
    .req     (mv_req),
    .busy    (mv_busy)
  );

  cdq_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_idle_mover: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !mv_busy)
    else $error("request taken while a block move is still running");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(DEPTH))
    else $error("element count beyond store depth");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count_q == '0) |-> (head == '0))
    else $error("empty sequence with nonzero head");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.re && ram_req.we && (ram_req.raddr == ram_req.waddr)))
    else $error("read and write to the same entry in one cycle");

endmodule

`default_nettype wire

/* rtl/cdq_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/cdq_mover.sv */
// Block mover: copies a run of entries by one slot, one element per cycle.
// Depends on cdq_pkg; drives the RAM through a ram_req_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module cdq_mover import cdq_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire move_cmd_t            cmd,
  input  wire logic [ELEM_BITS-1:0] rd_data,
  output ram_req_t                  req,
  output logic                      busy
);

  logic [CNT_W-1:0]  left;
  logic              wr_pend;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] dst;
  logic              up;
  logic [ADDR_W-1:0] wr_addr;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      left    <= '0;
      wr_pend <= 1'b0;
    end else if (cmd.start) begin
      left    <= cmd.moves;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= (left != '0);
      if (left != '0) begin
        left <= left - CNT_W'(1);
      end
    end
  end

  // addresses
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src <= cmd.src;
      dst <= cmd.dst;
      up  <= cmd.up;
    end else if (left != '0) begin
      wr_addr <= dst;
      src     <= up ? src + ADDR_W'(1) : src - ADDR_W'(1);
      dst     <= up ? dst + ADDR_W'(1) : dst - ADDR_W'(1);
    end
  end

  // read source now, write its data to the destination next cycle
  assign req.re    = (left != '0);
  assign req.raddr = src;
  assign req.we    = wr_pend;
  assign req.waddr = wr_addr;
  assign req.wdata = rd_data;
  assign busy      = (left != '0) | wr_pend;

endmodule

`default_nettype wire

/* test/deque_scoreboard_pkg.sv */
// Scoreboard for the circular deque testbench: tracks the element sequence
// and the replies it implies. Depends on cdq_pkg.
`timescale 1ns / 1ps

package deque_scoreboard_pkg;
  import cdq_pkg::*;

  class deque_scoreboard;
    typedef struct {
      logic [DATA_W-1:0] read_data;
      status_t           status;
      logic [CNT_W-1:0]  count;
    } reply_t;

    // logical view only; the physical head position never shows at the ports
    logic [ELEM_BITS-1:0] contents[$];
    reply_t               awaited[$];

    int unsigned faults;
    int unsigned replies_checked;
    int unsigned per_command[4];
    int unsigned range_hits;
    int unsigned full_hits;
    int unsigned peak_held;

    function int unsigned held();
      return contents.size();
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // apply one accepted request transfer and queue the reply it must produce
    function void note_request(cmd_t command, logic [CNT_W-1:0] position,
                               logic [DATA_W-1:0] write_data);
      reply_t      r;
      int unsigned n;
      int unsigned pos;
      n = contents.size();
      pos = 32'(position);
      r.read_data = '0;
      r.status = ST_OK;
      case (command)
        CMD_READ: begin
          if (pos < n) r.read_data = contents[pos];
          else r.status = ST_RANGE;
        end
        CMD_INSERT: begin
          // range check takes priority over full
          if (pos > n) r.status = ST_RANGE;
          else if (n >= DEPTH) r.status = ST_FULL;
          else contents.insert(pos, write_data[ELEM_BITS-1:0]);
        end
        CMD_ERASE: begin
          if (pos >= n) r.status = ST_RANGE;
          else contents.delete(pos);
        end
        default: contents.delete();
      endcase
      r.count = CNT_W'(contents.size());
      per_command[command]++;
      if (r.status == ST_RANGE) range_hits++;
      if (r.status == ST_FULL) full_hits++;
      if (contents.size() > peak_held) peak_held = contents.size();
      awaited.push_back(r);
    endfunction

    function void check_response(logic [DATA_W-1:0] read_data, status_t status,
                                 logic [CNT_W-1:0] count);
      reply_t want;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("response with nothing outstanding: data=%h status=%0d count=%0d",
                   read_data, status, count);
        return;
      end
      want = awaited.pop_front();
      replies_checked++;
      if (want.read_data !== read_data || want.status !== status ||
          want.count !== count) begin
        faults++;
        if (faults <= 10)
          $display({"mismatch on reply %0d: want data=%h status=%0d count=%0d, ",
                    "got data=%h status=%0d count=%0d"},
                   replies_checked, want.read_data, want.status, want.count,
                   read_data, status, count);
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        faults += awaited.size();
        $display("%0d replies never arrived", awaited.size());
      end
    endfunction
  endclass

endpackage

/* test/tb_top.sv */
// Top-level testbench for circular_deque_middle_insert_erase: directed and
// random command streams under varying back-pressure, replies scored live.
// Depends on cdq_pkg, cdq_if, the block itself and deque_scoreboard_pkg.
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;
  import deque_scoreboard_pkg::*;

  // worst item moves half the store; under a thousand items with heavy
  // stalls stay far below this limit
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned PHASE_ITEMS  = 205;

  logic clk;
  logic rst;

  cdq_req_if request_ch ();
  cdq_rsp_if response_ch ();

  circular_deque_middle_insert_erase dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  deque_scoreboard board = new();

  int unsigned send_idle_pct;   // chance per cycle that the sender holds off
  int unsigned recv_stall_pct;  // chance per cycle that ready is low
  int unsigned cycles;

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycles, board.outstanding());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Response side. Sampling happens in the active region at the edge, so the
  // values seen are the pre-edge ones; ready for the next cycle is then
  // re-drawn with exactly one NBA per edge.
  initial begin
    response_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && response_ch.valid && response_ch.ready)
        board.check_response(response_ch.read_data, response_ch.status,
                             response_ch.count);
      response_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One request transfer. An idle gap lowers valid before the transfer;
  // without a gap valid simply stays high for back-to-back transfers.
  task automatic send_request(cmd_t command, int unsigned position,
                              logic [DATA_W-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    request_ch.valid      <= 1'b1;
    request_ch.command    <= command;
    request_ch.position   <= position[CNT_W-1:0];
    request_ch.write_data <= data;
    do @(posedge clk); while (!request_ch.ready);
    board.note_request(command, position[CNT_W-1:0], data);
  endtask

  // index in [0, n-1], leaning on both ends where the shift lengths differ most
  function automatic int unsigned pick_index(int unsigned n);
    int unsigned sel;
    sel = $urandom_range(3);
    if (n == 0) return 0;
    if (sel == 0) return 0;
    if (sel == 1) return n - 1;
    return $urandom_range(n - 1);
  endfunction

  // Mostly well-formed commands against the current occupancy, with a small
  // share of out-of-range indices (the whole 11-bit field) and clears.
  task automatic random_item();
    int unsigned n;
    int unsigned sel;
    int unsigned bad;
    n   = board.held();
    sel = $urandom_range(99);
    bad = $urandom_range(2047 - n) + n;  // at or beyond count
    if (sel < 8) begin
      case ($urandom_range(2))
        0:       send_request(CMD_READ, bad, $urandom());
        1:       send_request(CMD_INSERT, (bad < 2047) ? bad + 1 : bad, $urandom());
        default: send_request(CMD_ERASE, bad, $urandom());
      endcase
    end else if (sel < 9) begin
      send_request(CMD_CLEAR, $urandom_range(2047), $urandom());
    end else if (sel < 38) begin
      send_request(CMD_READ, pick_index(n), $urandom());
    end else if (sel < 78) begin
      send_request(CMD_INSERT, pick_index(n + 1), $urandom());
    end else begin
      send_request(CMD_ERASE, pick_index(n), $urandom());
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    request_ch.valid      <= 1'b0;
    request_ch.command    <= CMD_READ;
    request_ch.position   <= '0;
    request_ch.write_data <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty-store errors, both shift directions, ties, extremes
    send_request(CMD_READ, 0, 32'h0);              // empty read
    send_request(CMD_ERASE, 0, 32'h0);             // empty erase
    send_request(CMD_INSERT, 1, 32'h1);            // insert past count
    send_request(CMD_CLEAR, 0, 32'h0);             // clear when empty
    send_request(CMD_INSERT, 0, 32'h0000_0000);
    send_request(CMD_INSERT, 1, 32'hFFFF_FFFF);    // append
    send_request(CMD_INSERT, 0, 32'hA5A5_A5A5);    // front shift, head wraps
    send_request(CMD_INSERT, 1, 32'h5A5A_5A5A);    // front side shorter
    send_request(CMD_INSERT, 2, 32'h1234_5678);    // tie: back side moves
    send_request(CMD_READ, 0, 32'h0);
    send_request(CMD_READ, 4, 32'h0);
    send_request(CMD_READ, 5, 32'h0);              // just past the end
    send_request(CMD_READ, 2047, 32'h0);
    send_request(CMD_INSERT, 2047, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 6, 32'h0);            // count + 1
    send_request(CMD_ERASE, 5, 32'h0);
    send_request(CMD_ERASE, 2047, 32'h0);
    send_request(CMD_ERASE, 2, 32'h0);             // tie: back side moves
    send_request(CMD_ERASE, 0, 32'h0);             // front side shifts
    send_request(CMD_ERASE, 2, 32'h0);             // last element
    send_request(CMD_READ, 1, 32'h0);
    send_request(CMD_CLEAR, 2047, 32'hFFFF_FFFF);
    send_request(CMD_READ, 0, 32'h0);              // empty after clear
    send_request(CMD_INSERT, 0, 32'hDEAD_BEEF);
    send_request(CMD_READ, 0, 32'h0);

    // --- random phases under each idling pattern
    repeat (PHASE_ITEMS) random_item();
    send_idle_pct = 77;
    repeat (PHASE_ITEMS) random_item();
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    repeat (PHASE_ITEMS) random_item();
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    repeat (PHASE_ITEMS) random_item();

    request_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    // give any stray extra reply time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();

    $display("transfers: %0d read, %0d insert, %0d erase, %0d clear; %0d replies checked",
             board.per_command[CMD_READ], board.per_command[CMD_INSERT],
             board.per_command[CMD_ERASE], board.per_command[CMD_CLEAR],
             board.replies_checked);
    $display("range errors %0d, full refusals %0d, peak occupancy %0d, failures %0d",
             board.range_hits, board.full_hits, board.peak_held, board.faults);
    if (board.faults == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_ram.sv
rtl/cdq_mover.sv
rtl/circular_deque_middle_insert_erase.sv
test/deque_scoreboard_pkg.sv
test/tb_top.sv
